// ===== sv/aie_pkg.sv =====
// package: opcodes, controller states and control/status structs
package aie_pkg;

	localparam logic [6:0] OP_READ  = 7'h10;
	localparam logic [6:0] OP_WRITE = 7'h11;
	localparam logic [6:0] OP_LOAD  = 7'h20;
	localparam logic [6:0] OP_STORE = 7'h21;
	localparam logic [6:0] OP_ADD   = 7'h30;
	localparam logic [6:0] OP_SUB   = 7'h31;
	localparam logic [6:0] OP_DIV   = 7'h32;
	localparam logic [6:0] OP_MUL   = 7'h33;
	localparam logic [6:0] OP_JMP   = 7'h40;
	localparam logic [6:0] OP_JNEG  = 7'h41;
	localparam logic [6:0] OP_JZ    = 7'h42;
	localparam logic [6:0] OP_HALT  = 7'h43;
	localparam logic [6:0] OP_JPOS  = 7'h55;
	localparam logic [6:0] OP_MOVE  = 7'h73;

	localparam logic [31:0] MAG_LIMIT = 32'h0000_FFFF;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_RD1,
		ST_RD2,
		ST_EXEC,
		ST_MUL,
		ST_DIV,
		ST_DIVFIN,
		ST_MOVE2,
		ST_FIN,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic latch;
		logic clr_step;
		logic rd_opd;
		logic rd_ptr;
		logic exec;
		logic mul_start;
		logic mul_fin;
		logic div_start;
		logic div_step;
		logic div_fin;
		logic move_wr;
		logic fin;
	} ctl_t;

	typedef struct packed {
		logic clr_done;
		logic div_done;
		logic div_by_zero;
		logic move_ok;
		logic mul_op;
		logic div_op;
		logic move_op;
	} sts_t;

endpackage

// ===== sv/aie_ctrl.sv =====
// controller state machine sequencing reads, arithmetic and result hand-off
module aie_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_fire,
	input  logic          out_fire,
	input  aie_pkg::sts_t sts,
	output aie_pkg::ctl_t ctl,
	output logic          busy,
	output logic          res_valid
);
	import aie_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLEAR;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:  if (sts.clr_done) state_d = ST_IDLE;
			ST_IDLE:   if (in_fire) state_d = ST_RD1;
			ST_RD1:    state_d = ST_RD2;
			ST_RD2:    state_d = ST_EXEC;
			ST_EXEC: begin
				if (sts.mul_op) state_d = ST_MUL;
				else if (sts.div_op && !sts.div_by_zero) state_d = ST_DIV;
				else if (sts.move_op && sts.move_ok) state_d = ST_MOVE2;
				else state_d = ST_FIN;
			end
			ST_MUL:    state_d = ST_FIN;
			ST_DIV:    if (sts.div_done) state_d = ST_DIVFIN;
			ST_DIVFIN: state_d = ST_FIN;
			ST_MOVE2:  state_d = ST_FIN;
			ST_FIN:    state_d = ST_OUT;
			ST_OUT:    if (out_fire) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		busy = 1'b1;
		res_valid = 1'b0;
		unique case (state_q)
			ST_CLEAR: ctl.clr_step = 1'b1;
			ST_IDLE: begin
				busy = 1'b0;
				ctl.latch = in_fire;
			end
			ST_RD1:   ctl.rd_opd = 1'b1;
			ST_RD2: ;
			ST_EXEC: begin
				ctl.exec = 1'b1;
				ctl.mul_start = sts.mul_op;
				ctl.div_start = sts.div_op && !sts.div_by_zero;
				ctl.rd_ptr = sts.move_op && sts.move_ok;
			end
			ST_MUL:    ctl.mul_fin = 1'b1;
			ST_DIV:    ctl.div_step = 1'b1;
			ST_DIVFIN: ctl.div_fin = 1'b1;
			ST_MOVE2:  ctl.move_wr = 1'b1;
			ST_FIN:    ctl.fin = 1'b1;
			ST_OUT:    res_valid = 1'b1;
			default: ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q == ST_RD1)
		else $error("accepted request did not start a read");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && !out_fire) |=> state_q == ST_OUT)
		else $error("result dropped before hand-off");
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.fin |=> res_valid)
		else $error("finish not followed by result");
endmodule

// ===== sv/aie_divider.sv =====
// iterative unsigned restoring divider, one quotient bit per cycle while step is asserted
module aie_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        step,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic [31:0] quotient,
	output logic        done
);
	logic [31:0] rem_q, quo_q, dsr_q;
	logic [5:0]  cnt_q;
	logic [32:0] trial;
	logic [31:0] shifted;

	assign shifted = {rem_q[30:0], quo_q[31]};
	assign trial = {1'b0, shifted} - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 6'd32;
		end else if (step && cnt_q != '0) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (step && cnt_q != '0) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
	assign done = (cnt_q == 6'd1) && step;
endmodule

// ===== sv/aie_datapath.sv =====
// datapath: cell memory, accumulator, arithmetic and result registers
module aie_datapath #(
	parameter int MEM_CELLS = 100
) (
	input  logic          clk,
	input  logic          arst_n,
	input  aie_pkg::ctl_t ctl,
	output aie_pkg::sts_t sts,
	input  logic [6:0]    cmd,
	input  logic [6:0]    operand,
	input  logic [31:0]   in_value,
	output logic [31:0]   acc_out,
	output logic [31:0]   out_value,
	output logic          out_valid,
	output logic          jump_taken,
	output logic [6:0]    jump_target,
	output logic          halt,
	output logic          overflow,
	output logic          div_zero,
	output logic          bad_address
);
	import aie_pkg::*;

	localparam int AW = (MEM_CELLS > 1) ? $clog2(MEM_CELLS) : 1;

	logic [31:0] mem [MEM_CELLS];
	logic [31:0] rd_q;
	logic [6:0]  cmd_q, opd_q;
	logic [31:0] val_q, acc_q, m_q, prod_q;
	logic [AW-1:0] clr_q;
	logic        ok_q, accok_q, negq_q;
	logic        bad_q, dz_q, ovf_q, hlt_q, jt_q;
	logic [31:0] res_acc_q, res_out_q;
	logic        res_ov_q;

	logic        ok, acc_in, arith, is_jump, cond, we;
	logic        bad_d, dz_d, ovf_d, hlt_d, jt_d;
	logic [AW-1:0] waddr, raddr;
	logic [31:0] wdata, mag_a, mag_b, quo, mag_acc;
	logic        div_done;

	function automatic logic [31:0] mag(input logic [31:0] v);
		mag = v[31] ? (32'd0 - v) : v;
	endfunction

	assign ok = {25'd0, opd_q} < 32'(MEM_CELLS);
	assign acc_in = acc_q < 32'(MEM_CELLS);
	assign arith = (cmd_q == OP_ADD) || (cmd_q == OP_SUB) ||
		(cmd_q == OP_DIV) || (cmd_q == OP_MUL);
	assign is_jump = (cmd_q == OP_JMP) || (cmd_q == OP_JNEG) ||
		(cmd_q == OP_JZ) || (cmd_q == OP_JPOS);
	assign mag_acc = mag(acc_q);

	always_comb begin
		unique case (cmd_q)
			OP_JMP:  cond = 1'b1;
			OP_JNEG: cond = acc_q[31];
			OP_JZ:   cond = acc_q == '0;
			OP_JPOS: cond = acc_q != '0 && !acc_q[31];
			default: cond = 1'b0;
		endcase
	end

	assign sts.clr_done = (32'(clr_q) == 32'(MEM_CELLS - 1));
	assign sts.div_by_zero = rd_q == '0;
	assign sts.move_ok = ok && accok_q;
	assign sts.mul_op = ok && cmd_q == OP_MUL;
	assign sts.div_op = ok && cmd_q == OP_DIV;
	assign sts.move_op = cmd_q == OP_MOVE;
	assign sts.div_done = div_done;

	// read address selection
	always_comb begin
		if (ctl.rd_ptr) raddr = acc_q[AW-1:0];
		else raddr = opd_q[AW-1:0];
	end

	// write port
	always_comb begin
		we = 1'b0;
		waddr = opd_q[AW-1:0];
		wdata = '0;
		if (ctl.clr_step) begin
			we = 1'b1;
			waddr = clr_q;
		end else if (ctl.exec && ok) begin
			if (cmd_q == OP_READ) begin
				we = 1'b1;
				wdata = val_q;
			end else if (cmd_q == OP_STORE) begin
				we = 1'b1;
				wdata = acc_q;
			end
		end else if (ctl.move_wr) begin
			we = {1'b0, rd_q} < 33'(MEM_CELLS);
			waddr = rd_q[AW-1:0];
			wdata = m_q;
		end else if (ctl.fin && arith && ok && mag_acc >= MAG_LIMIT) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			acc_q <= '0;
		end else begin
			if (ctl.clr_step) clr_q <= clr_q + AW'(1);
			if (ctl.exec && ok) begin
				if (cmd_q == OP_LOAD) acc_q <= rd_q;
				else if (cmd_q == OP_ADD) acc_q <= acc_q + rd_q;
				else if (cmd_q == OP_SUB) acc_q <= acc_q - rd_q;
			end
			if (ctl.mul_fin) acc_q <= prod_q;
			if (ctl.div_fin) acc_q <= negq_q ? (32'd0 - quo) : quo;
		end
	end

	assign mag_a = mag(acc_q);
	assign mag_b = mag(rd_q);

	aie_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.div_start),
		.step     (ctl.div_step),
		.dividend (mag_a),
		.divisor  (mag_b),
		.quotient (quo),
		.done     (div_done)
	);

	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			cmd_q <= cmd;
			opd_q <= operand;
			val_q <= in_value;
		end
		if (ctl.rd_opd) accok_q <= acc_in;
		if (ctl.exec) begin
			m_q <= rd_q;
			negq_q <= acc_q[31] ^ rd_q[31];
			prod_q <= 32'(acc_q * rd_q);
		end
	end

	always_comb begin
		bad_d = 1'b0;
		dz_d = 1'b0;
		ovf_d = 1'b0;
		hlt_d = 1'b0;
		jt_d = 1'b0;
		if (!ok && (cmd_q == OP_READ || cmd_q == OP_WRITE || cmd_q == OP_LOAD ||
			cmd_q == OP_STORE || arith)) bad_d = 1'b1;
		if (cmd_q == OP_MOVE && !(ok && accok_q)) bad_d = 1'b1;
		if (is_jump && cond) begin
			if (ok) jt_d = 1'b1;
			else bad_d = 1'b1;
		end
		if (cmd_q == OP_HALT) hlt_d = 1'b1;
		if (ok && cmd_q == OP_DIV && rd_q == '0) dz_d = 1'b1;
		if (cmd_q == OP_READ && !val_q[31] && val_q > MAG_LIMIT) ovf_d = 1'b1;
	end

	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			bad_q <= bad_d;
			dz_q <= dz_d;
			ovf_q <= ovf_d;
			hlt_q <= hlt_d;
			jt_q <= jt_d;
			res_out_q <= (cmd_q == OP_WRITE && ok) ? rd_q : '0;
		end
		if (ctl.move_wr && !({1'b0, rd_q} < 33'(MEM_CELLS))) bad_q <= 1'b1;
		if (ctl.fin) begin
			res_acc_q <= acc_q;
			res_ov_q <= arith && ok && mag_acc >= MAG_LIMIT;
		end
	end

	assign acc_out = res_acc_q;
	assign out_value = res_out_q;
	assign out_valid = cmd_q == OP_WRITE && ok;
	assign jump_taken = jt_q;
	assign jump_target = jt_q ? opd_q : 7'd0;
	assign halt = hlt_q || res_ov_q;
	assign overflow = ovf_q || res_ov_q;
	assign div_zero = dz_q;
	assign bad_address = bad_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clr_step |-> we)
		else $error("clear sweep without write");
	assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.exec && cmd_q == OP_LOAD && ok) |=> acc_q == $past(rd_q))
		else $error("load mismatch");
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.div_fin |-> $past(ctl.div_step))
		else $error("divide finished without steps");
endmodule

// ===== sv/accumulator_instruction_executor.sv =====
// top level: accumulator machine instruction executor
//  channel | signals                                  | dir
//  request | in_valid in_ready cmd operand in_value   | in
//  result  | res_valid res_ready acc_out out_value .. | out
// load/store/add/sub/jumps/halt/read/write: states RD1, RD2, EXEC, FIN, OUT after accept
// multiply and move add a MUL or MOVE2 state; divide by nonzero adds DIV (32-step divider) and DIVFIN
// after reset a clear sweep writes every cell, no request taken
// result holds until res_ready; no new request until the result is taken
module accumulator_instruction_executor #(
	parameter int MEM_CELLS = 100
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [6:0]  cmd,
	input  logic [6:0]  operand,
	input  logic [31:0] in_value,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [31:0] acc_out,
	output logic [31:0] out_value,
	output logic        out_valid,
	output logic        jump_taken,
	output logic [6:0]  jump_target,
	output logic        halt,
	output logic        overflow,
	output logic        div_zero,
	output logic        bad_address
);
	import aie_pkg::*;

	ctl_t ctl;
	sts_t sts;
	logic busy, in_fire, out_fire;

	assign in_ready = !busy;
	assign in_fire = in_valid && in_ready;
	assign out_fire = res_valid && res_ready;

	aie_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.out_fire  (out_fire),
		.sts       (sts),
		.ctl       (ctl),
		.busy      (busy),
		.res_valid (res_valid)
	);

	aie_datapath #(.MEM_CELLS(MEM_CELLS)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.sts         (sts),
		.cmd         (cmd),
		.operand     (operand),
		.in_value    (in_value),
		.acc_out     (acc_out),
		.out_value   (out_value),
		.out_valid   (out_valid),
		.jump_taken  (jump_taken),
		.jump_target (jump_target),
		.halt        (halt),
		.overflow    (overflow),
		.div_zero    (div_zero),
		.bad_address (bad_address)
	);
endmodule
